// File: rtl/core/fta_pkg.sv
// shared types and constants for the fixed-timestep accumulator
package fta_pkg;

  localparam int STAMP_WIDTH    = 32;
  localparam int STEP_CAP_LIMIT = 64;

  localparam int RATE_W   = 10;
  localparam int CAP_W    = 7;
  localparam int PERIOD_W = 20;
  localparam int BUDGET_W = 27;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [PERIOD_W-1:0] US_PER_SECOND = PERIOD_W'(1000000);
  localparam logic [RATE_W-1:0]   RATE_MIN      = RATE_W'(1);
  localparam logic [RATE_W-1:0]   RATE_MAX      = RATE_W'(1000);
  localparam logic [RATE_W-1:0]   RATE_RESET    = RATE_W'(60);
  localparam logic [CAP_W-1:0]    CAP_MIN       = CAP_W'(1);
  localparam logic [CAP_W-1:0]    CAP_MAX       = CAP_W'(STEP_CAP_LIMIT);
  localparam logic [CAP_W-1:0]    CAP_RESET     = CAP_W'(5);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(1000000 / 60);
  localparam logic [BUDGET_W-1:0] BUDGET_RESET  = BUDGET_W'(5 * (1000000 / 60));

  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = CFG_IDX_W'(1);

  typedef struct packed {
    logic div_init;
    logic div_step;
    logic bud_load;
    logic item_load;
    logic drain_step;
    logic rem_load;
    logic out_load;
  } fta_cmd_t;

  typedef struct packed {
    logic div_last;
    logic drain_go;
    logic out_free;
  } fta_stat_t;

endpackage

// File: rtl/core/fta_ctrl.sv
// controller state machine for the fixed-timestep accumulator
module fta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_ready,
  input  fta_pkg::fta_stat_t stat,
  output fta_pkg::fta_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_BUD   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DRAIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_BUD;
        end
      end
      S_BUD: begin
        cmd.bud_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DRAIN: begin
        if (stat.drain_go) begin
          cmd.drain_step = 1'b1;
        end else begin
          cmd.rem_load = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/fta_dp.sv
// datapath: config registers, period divider, delta budget and drain loop
module fta_dp #(
  parameter int STAMP_W = fta_pkg::STAMP_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fta_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_action,
  input  logic [STAMP_W-1:0]               in_now_us,
  input  fta_pkg::fta_cmd_t                cmd,
  output fta_pkg::fta_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fta_pkg::CAP_W-1:0]        out_steps
);

  localparam int CMP_W = (STAMP_W > fta_pkg::BUDGET_W) ? STAMP_W : fta_pkg::BUDGET_W;

  logic [fta_pkg::RATE_W-1:0]   rate_r;
  logic [fta_pkg::CAP_W-1:0]    max_r;
  logic [fta_pkg::PERIOD_W-1:0] period_r;
  logic [fta_pkg::BUDGET_W-1:0] budget_r;
  logic                         started_r;
  logic [STAMP_W-1:0]           last_r;
  logic [fta_pkg::PERIOD_W-1:0] rem_r;
  logic [fta_pkg::BUDGET_W-1:0] acc_r;
  logic [fta_pkg::CAP_W-1:0]    cnt_r;
  logic                         out_valid_r;
  logic [fta_pkg::CAP_W-1:0]    out_steps_r;

  logic [fta_pkg::RATE_W-1:0]    div_rem_r;
  logic [fta_pkg::PERIOD_W-1:0]  div_dvd_r;
  logic [fta_pkg::PERIOD_W-1:0]  div_quot_r;
  logic [fta_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic [fta_pkg::RATE_W-1:0]   rate_c;
  logic [fta_pkg::CAP_W-1:0]    cap_v;
  logic [fta_pkg::CAP_W-1:0]    cap_c;
  logic [fta_pkg::RATE_W:0]     trial;
  logic                         trial_ge;
  logic [fta_pkg::RATE_W:0]     trial_sub;
  logic [STAMP_W-1:0]           delta;
  logic [CMP_W-1:0]             delta_x;
  logic [CMP_W-1:0]             budget_x;
  logic [fta_pkg::BUDGET_W-1:0] capped;
  logic [fta_pkg::BUDGET_W-1:0] acc_load;

  // clamp written values
  always_comb begin
    if (cfg_wdata == '0) begin
      rate_c = fta_pkg::RATE_MIN;
    end else if (cfg_wdata > fta_pkg::RATE_MAX) begin
      rate_c = fta_pkg::RATE_MAX;
    end else begin
      rate_c = cfg_wdata;
    end
    cap_v = cfg_wdata[fta_pkg::CAP_W-1:0];
    if (cap_v == '0) begin
      cap_c = fta_pkg::CAP_MIN;
    end else if (cap_v > fta_pkg::CAP_MAX) begin
      cap_c = fta_pkg::CAP_MAX;
    end else begin
      cap_c = cap_v;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial     = {div_rem_r, div_dvd_r[fta_pkg::PERIOD_W-1]};
  assign trial_ge  = trial >= {1'b0, rate_r};
  assign trial_sub = trial - {1'b0, rate_r};

  // wrapping delta capped at the budget
  assign delta    = in_now_us - last_r;
  assign delta_x  = CMP_W'(delta);
  assign budget_x = CMP_W'(budget_r);
  always_comb begin
    if (delta_x > budget_x) begin
      capped = budget_r;
    end else begin
      capped = delta_x[fta_pkg::BUDGET_W-1:0];
    end
    if (in_action || !started_r) begin
      acc_load = '0;
    end else begin
      acc_load = fta_pkg::BUDGET_W'(rem_r) + capped;
    end
  end

  assign stat.div_last = (div_cnt_r == fta_pkg::DIV_CNT_W'(fta_pkg::DIV_STEPS - 1));
  assign stat.drain_go = (acc_r >= fta_pkg::BUDGET_W'(period_r)) && (cnt_r < max_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_steps = out_steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= fta_pkg::RATE_RESET;
      max_r       <= fta_pkg::CAP_RESET;
      period_r    <= fta_pkg::PERIOD_RESET;
      budget_r    <= fta_pkg::BUDGET_RESET;
      started_r   <= 1'b0;
      last_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fta_pkg::REG_TICK_RATE: rate_r <= rate_c;
          fta_pkg::REG_MAX_STEPS: max_r  <= cap_c;
          default: ;
        endcase
        started_r <= 1'b0;
        last_r    <= '0;
        rem_r     <= '0;
      end
      if (cmd.bud_load) begin
        period_r <= div_quot_r;
        budget_r <= fta_pkg::BUDGET_W'(max_r) * fta_pkg::BUDGET_W'(div_quot_r);
      end
      if (cmd.item_load) begin
        if (in_action) begin
          started_r <= 1'b0;
          last_r    <= '0;
        end else begin
          started_r <= 1'b1;
          last_r    <= in_now_us;
        end
      end
      if (cmd.rem_load) begin
        rem_r <= acc_r[fta_pkg::PERIOD_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem_r  <= '0;
      div_dvd_r  <= fta_pkg::US_PER_SECOND;
      div_quot_r <= '0;
      div_cnt_r  <= '0;
    end else if (cmd.div_step) begin
      div_rem_r  <= trial_ge ? trial_sub[fta_pkg::RATE_W-1:0] : trial[fta_pkg::RATE_W-1:0];
      div_dvd_r  <= {div_dvd_r[fta_pkg::PERIOD_W-2:0], 1'b0};
      div_quot_r <= {div_quot_r[fta_pkg::PERIOD_W-2:0], trial_ge};
      div_cnt_r  <= div_cnt_r + fta_pkg::DIV_CNT_W'(1);
    end
    if (cmd.item_load) begin
      acc_r <= acc_load;
      cnt_r <= '0;
    end else if (cmd.drain_step) begin
      acc_r <= acc_r - fta_pkg::BUDGET_W'(period_r);
      cnt_r <= cnt_r + fta_pkg::CAP_W'(1);
    end
    if (cmd.out_load) begin
      out_steps_r <= cnt_r;
    end
  end

endmodule

// File: rtl/core/fixed_timestep_accumulator.sv
// top level of the fixed-timestep accumulator
//
//  channel  direction  signals
//  in       input      in_valid, in_ready, in_action, in_now_us
//  out      output     out_valid, out_ready, out_steps
//  cfg      input      cfg_we, cfg_index, cfg_wdata
//
// an advance or restart transaction runs the drain loop, which subtracts
// one period per cycle.
// a config write reruns the period divider, one quotient bit per cycle.
// reset is synchronous; the period and budget come up at 60 Hz and 5 steps.
// a result waiting on out_ready stalls the next transaction, backing up input.
module fixed_timestep_accumulator #(
  parameter int STAMP_WIDTH = fta_pkg::STAMP_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [STAMP_WIDTH-1:0]         in_now_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fta_pkg::CAP_W-1:0]      out_steps
);

  fta_pkg::fta_cmd_t  cmd;
  fta_pkg::fta_stat_t stat;

  fta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fta_dp #(
    .STAMP_W (STAMP_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_action (in_action),
    .in_now_us (in_now_us),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_steps (out_steps)
  );

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the fixed-timestep accumulator
module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 18;
  localparam int SETTLE       = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_PHASES     = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;
  localparam int N_DIRECTED   = 18;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic                            action;
    logic [fta_pkg::STAMP_WIDTH-1:0] now_us;
    logic                            known;
    logic [fta_pkg::CAP_W-1:0]       steps;
  } stim_row_t;

  // reset settings: period 16666, cap 5, budget 83330
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_ADVANCE, 32'd0,                    1'b1, 7'd0},
    '{ACT_ADVANCE, 32'd16666,                1'b1, 7'd1},
    '{ACT_ADVANCE, 32'd16666,                1'b1, 7'd0},
    '{ACT_ADVANCE, 32'd99996,                1'b1, 7'd5},
    '{ACT_ADVANCE, 32'hFFFF_FFFF,            1'b1, 7'd5},
    '{ACT_ADVANCE, 32'd16665,                1'b1, 7'd1},
    '{ACT_RESTART, 32'hFFFF_FFFF,            1'b1, 7'd0},
    '{ACT_ADVANCE, 32'hFFFF_FFFF,            1'b1, 7'd0},
    '{ACT_ADVANCE, 32'h0000_0000,            1'b1, 7'd0},
    '{ACT_ADVANCE, 32'd16665,                1'b1, 7'd1},
    '{ACT_ADVANCE, 32'd33330,                1'b1, 7'd0},
    '{ACT_ADVANCE, 32'd33331,                1'b1, 7'd1},
    '{ACT_RESTART, 32'h0000_0000,            1'b1, 7'd0},
    '{ACT_ADVANCE, 32'hAAAA_AAAA,            1'b1, 7'd0},
    '{ACT_ADVANCE, 32'hAAAA_AAAA + 32'd50098, 1'b1, 7'd3},
    '{ACT_ADVANCE, 32'h5555_5555,            1'b0, 7'd0},
    '{ACT_ADVANCE, 32'h5555_5555 + 32'd16566, 1'b0, 7'd0},
    '{ACT_RESTART, 32'h5555_5555,            1'b1, 7'd0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [fta_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [fta_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_action = ACT_ADVANCE;
  logic [fta_pkg::STAMP_WIDTH-1:0] in_now_us = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [fta_pkg::CAP_W-1:0]       out_steps;

  logic                            row_known = 1'b0;
  logic [fta_pkg::CAP_W-1:0]       row_steps = '0;
  bit                              steady = 1'b0;
  bit                              hold_req = 1'b0;

  logic                            sched_started;
  logic [fta_pkg::STAMP_WIDTH-1:0] sched_last;
  logic [fta_pkg::PERIOD_W-1:0]    sched_rem;
  logic [fta_pkg::PERIOD_W-1:0]    sched_period;
  logic [fta_pkg::RATE_W-1:0]      sched_rate;
  logic [fta_pkg::CAP_W-1:0]       sched_cap;

  logic [fta_pkg::CAP_W-1:0]       granted_q [$];
  logic [fta_pkg::CAP_W-1:0]       predicted_steps;
  logic [fta_pkg::CAP_W-1:0]       oldest_grant;
  logic [fta_pkg::STAMP_WIDTH-1:0] stamp_cursor = '0;
  int unsigned                     failures = 0;
  int unsigned                     cycle_count = 0;

  fixed_timestep_accumulator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_now_us (in_now_us),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_steps (out_steps)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void clear_schedule();
    sched_rem     = '0;
    sched_last    = '0;
    sched_started = 1'b0;
  endfunction

  function automatic void reload_period();
    sched_period = fta_pkg::PERIOD_W'(32'd1000000 / 32'(sched_rate));
    clear_schedule();
  endfunction

  function automatic void reset_schedule();
    sched_rate = fta_pkg::RATE_RESET;
    sched_cap  = fta_pkg::CAP_RESET;
    reload_period();
  endfunction

  function automatic void apply_reg_write(input logic [fta_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [fta_pkg::CFG_DATA_W-1:0] data);
    logic [fta_pkg::RATE_W-1:0] rate_v;
    logic [fta_pkg::CAP_W-1:0]  cap_v;
    rate_v = data[fta_pkg::RATE_W-1:0];
    cap_v  = data[fta_pkg::CAP_W-1:0];
    if (idx == fta_pkg::REG_TICK_RATE) begin
      if (rate_v < fta_pkg::RATE_MIN) sched_rate = fta_pkg::RATE_MIN;
      else if (rate_v > fta_pkg::RATE_MAX) sched_rate = fta_pkg::RATE_MAX;
      else sched_rate = rate_v;
    end else if (idx == fta_pkg::REG_MAX_STEPS) begin
      if (cap_v < fta_pkg::CAP_MIN) sched_cap = fta_pkg::CAP_MIN;
      else if (cap_v > fta_pkg::CAP_MAX) sched_cap = fta_pkg::CAP_MAX;
      else sched_cap = cap_v;
    end
    reload_period();
  endfunction

  function automatic logic [fta_pkg::CAP_W-1:0] predict_steps(
      input logic act, input logic [fta_pkg::STAMP_WIDTH-1:0] now);
    logic [fta_pkg::STAMP_WIDTH-1:0] gap;
    logic [63:0]                     budget;
    logic [63:0]                     elapsed;
    logic [63:0]                     acc;
    int unsigned                     n;
    n = 0;
    if (act == ACT_RESTART) begin
      clear_schedule();
      return '0;
    end
    if (!sched_started) begin
      sched_last    = now;
      sched_started = 1'b1;
      return '0;
    end
    gap        = now - sched_last;
    sched_last = now;
    budget  = 64'(sched_cap) * 64'(sched_period);
    elapsed = (64'(gap) > budget) ? budget : 64'(gap);
    acc     = 64'(sched_rem) + elapsed;
    while (acc >= 64'(sched_period) && n < 32'(sched_cap)) begin
      acc = acc - 64'(sched_period);
      n++;
    end
    sched_rem = acc[fta_pkg::PERIOD_W-1:0];
    return fta_pkg::CAP_W'(n);
  endfunction

  function automatic void log_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) $display("%s", what);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && in_ready) begin
      predicted_steps = predict_steps(in_action, in_now_us);
      granted_q.push_back(row_known ? row_steps : predicted_steps);
    end
    if (rst_n && out_valid && out_ready) begin
      if (granted_q.size() == 0) begin
        log_failure($sformatf("unexpected transaction: steps %0d", out_steps));
      end else begin
        oldest_grant = granted_q.pop_front();
        if (out_steps !== oldest_grant)
          log_failure($sformatf("steps mismatch: expected %0d, got %0d",
                                oldest_grant, out_steps));
      end
    end
  end

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(input logic act, input logic [fta_pkg::STAMP_WIDTH-1:0] stamp,
                           input logic known, input logic [fta_pkg::CAP_W-1:0] steps);
    in_valid  <= 1'b1;
    in_action <= act;
    in_now_us <= stamp;
    row_known <= known;
    row_steps <= steps;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (granted_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fta_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fta_pkg::CFG_DATA_W-1:0] data);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  task automatic pick_item(output logic act,
                           output logic [fta_pkg::STAMP_WIDTH-1:0] stamp);
    int unsigned                     roll;
    logic [63:0]                     budget;
    logic [fta_pkg::STAMP_WIDTH-1:0] gap;
    roll   = $urandom_range(0, 99);
    budget = 64'(sched_cap) * 64'(sched_period);
    act    = ACT_ADVANCE;
    gap    = '0;
    if (roll < 4) begin
      act   = ACT_RESTART;
      stamp = $urandom;
    end else begin
      if (roll < 8) begin
        stamp_cursor = $urandom;
      end else if (roll < 11) begin
        // just below the counter wrap
        stamp_cursor = '1 - fta_pkg::STAMP_WIDTH'($urandom_range(0, 2 * 32'(sched_period)));
      end else begin
        if (roll < 25)
          gap = fta_pkg::STAMP_WIDTH'($urandom_range(0, 32'(sched_period)));
        else if (roll < 75)
          gap = fta_pkg::STAMP_WIDTH'($urandom_range(0, 32'(sched_cap)) * 32'(sched_period)
                                      + $urandom_range(0, 100) - 32'd50);
        else if (roll < 88)
          gap = fta_pkg::STAMP_WIDTH'(budget) + fta_pkg::STAMP_WIDTH'($urandom);
        else
          gap = fta_pkg::STAMP_WIDTH'(budget + 64'($urandom_range(0, 2)) - 64'd1);
        stamp_cursor = stamp_cursor + gap;
      end
      stamp = stamp_cursor;
    end
  endtask

  initial begin
    logic                            act;
    logic [fta_pkg::STAMP_WIDTH-1:0] stamp;
    logic [fta_pkg::CFG_DATA_W-1:0]  rate_w;
    logic [fta_pkg::CFG_DATA_W-1:0]  cap_w;
    reset_schedule();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++)
      send_item(directed_rows[r].action, directed_rows[r].now_us,
                directed_rows[r].known, directed_rows[r].steps);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin rate_w = 10'd1000; cap_w = 10'd64;  end
        1: begin rate_w = 10'd0;    cap_w = 10'd0;   end
        2: begin rate_w = 10'd1023; cap_w = 10'd1023; end
        3: begin rate_w = 10'd60;   cap_w = 10'h2A5; end
        4: begin rate_w = 10'd1;    cap_w = 10'h17F; end
        5: begin rate_w = 10'd1000; cap_w = 10'd1;   end
        6: begin rate_w = 10'd1;    cap_w = 10'd64;  end
        default: begin
          rate_w = fta_pkg::CFG_DATA_W'($urandom_range(1, 1000));
          cap_w  = fta_pkg::CFG_DATA_W'($urandom_range(0, 1023));
        end
      endcase
      wait_results();
      if (ph % 2 == 1) begin
        write_reg(fta_pkg::REG_MAX_STEPS, cap_w);
        write_reg(fta_pkg::REG_TICK_RATE, rate_w);
      end else begin
        write_reg(fta_pkg::REG_TICK_RATE, rate_w);
        write_reg(fta_pkg::REG_MAX_STEPS, cap_w);
      end
      steady = (ph == 0);
      // stall the result side so the block backs up into its input
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick_item(act, stamp);
        send_item(act, stamp, 1'b0, '0);
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_results();
      end
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && granted_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
